// ===== hw/rtl/chgw_pkg.sv =====
// ----------------------------------------------------------------------------
// chgw_pkg
// Types and constants shared by the convex hull (gift wrap) block.
// ----------------------------------------------------------------------------
`default_nettype none

package chgw_pkg;

  localparam int unsigned MaxPointsDef = 64;
  localparam int unsigned CoordW       = 16;
  localparam int unsigned IdxW         = 6;
  localparam int unsigned MinWrap      = 3;
  localparam int unsigned QDepth       = 2;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic                     last_point;
  } pt_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] hull_x;
    logic signed [CoordW-1:0] hull_y;
    logic [IdxW-1:0]          vertex_index;
    logic                     last_vertex;
  } hull_out_t;

  // one classified beat from front to back
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     store;
    logic                     last;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SMALL0,
    ST_SMALL1,
    ST_MIN,
    ST_EMIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DECIDE
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/chgw_front.sv =====
// ----------------------------------------------------------------------------
// chgw_front
// Queues point beats for the back, marking those past capacity as unstored.
// ----------------------------------------------------------------------------
`default_nettype none

module chgw_front import chgw_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid,
  output logic        in_stall,
  input  wire pt_in_t in_data,
  output logic        cmd_valid_o,
  input  wire logic   cmd_pop_i,
  output cmd_t        cmd_o
);

  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  cmd_t            q_mem [QDepth];
  logic            wp_q, rp_q;
  logic [1:0]      fill_q;
  logic [CntW-1:0] cnt_q;
  logic            push;

  assign in_stall    = (fill_q == 2'(QDepth));
  assign push        = in_valid && !in_stall;
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = q_mem[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wp_q].x     <= in_data.point_x;
      q_mem[wp_q].y     <= in_data.point_y;
      q_mem[wp_q].last  <= in_data.last_point;
      q_mem[wp_q].store <= (cnt_q < CntW'(MaxPoints));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fill_q <= 2'd0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
        if (in_data.last_point) cnt_q <= '0;
        else if (cnt_q < CntW'(MaxPoints)) cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_pop_i) rp_q <= ~rp_q;
      fill_q <= fill_q + 2'(push) - 2'(cmd_pop_i);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chgw_back.sv =====
// ----------------------------------------------------------------------------
// chgw_back
// Point store and Jarvis march sequencer; scans compare stored points one by one.
// ----------------------------------------------------------------------------
`default_nettype none

module chgw_back import chgw_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  output logic      cmd_pop_o,
  input  wire cmd_t cmd_i,
  output logic      out_valid,
  input  wire logic out_stall,
  output hull_out_t out_data
);

  localparam int unsigned AW   = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned DW   = CoordW + 1;
  localparam int unsigned PW   = 2 * DW;

  logic signed [CoordW-1:0] xs_mem [MaxPoints];
  logic signed [CoordW-1:0] ys_mem [MaxPoints];
  logic [MaxPoints-1:0] rem_q, rem_d;
  logic [CntW-1:0] n_q, n_d, j_q, j_d, emitted_q, emitted_d, jd_m1;
  logic [AW-1:0] start_q, start_d, base_q, base_d, cur_q, cur_d, rd_idx;
  logic have_q, have_d;
  state_e st_q, st_d;
  logic signed [CoordW-1:0] rx_q, ry_q;
  logic signed [CoordW-1:0] bx_q, by_q, cx_q, cy_q, sx_q, sy_q, sx_d, sy_d;
  logic signed [CoordW-1:0] ox_d, oy_d, ox0_q, oy0_q;
  logic [AW-1:0] oidx_d;
  logic olast_d, opush;
  logic fin_d;

  hull_out_t obuf_q;
  logic      ov_q;
  logic      ofree;
  hull_out_t pend_q;
  logic      pv_q;

  assign ofree     = !ov_q || !out_stall;
  assign out_valid = ov_q;
  assign out_data  = obuf_q;

  logic wr_en;
  assign wr_en = cmd_pop_o && cmd_i.store;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      xs_mem[n_q[AW-1:0]] <= cmd_i.x;
      ys_mem[n_q[AW-1:0]] <= cmd_i.y;
    end
    rx_q <= xs_mem[rd_idx];
    ry_q <= ys_mem[rd_idx];
  end

  // read address for next cycle's registered data
  assign jd_m1 = j_d - 1'b1;
  always_comb begin
    rd_idx = j_q[AW-1:0];
    if (st_q == ST_SMALL1) rd_idx = jd_m1[AW-1:0];
  end

  // geometry from base (b), current choice (c), candidate (r)
  logic signed [DW-1:0] x1, y1, x2, y2;
  logic signed [PW-1:0] p1, p2;
  logic signed [PW:0]   d1, d2, det;
  assign x1  = DW'(cx_q) - DW'(bx_q);
  assign y1  = DW'(cy_q) - DW'(by_q);
  assign x2  = DW'(rx_q) - DW'(bx_q);
  assign y2  = DW'(ry_q) - DW'(by_q);
  assign p1  = x1 * y2;
  assign p2  = x2 * y1;
  assign det = (PW+1)'(p1) - (PW+1)'(p2);
  assign d1  = (PW+1)'(x2 * x2) + (PW+1)'(y2 * y2);
  assign d2  = (PW+1)'(x1 * x1) + (PW+1)'(y1 * y1);
  logic better;
  assign better = (det < 0) || (det == 0 && d1 > d2);

  logic lower;
  assign lower = (ry_q < sy_q) || (ry_q == sy_q && rx_q < sx_q);

  always_comb begin
    st_d = st_q; n_d = n_q; j_d = j_q; rem_d = rem_q; start_d = start_q;
    base_d = base_q; cur_d = cur_q; have_d = have_q; emitted_d = emitted_q;
    sx_d = sx_q; sy_d = sy_q; cmd_pop_o = 1'b0; fin_d = 1'b0;
    unique case (st_q)
      ST_LOAD: begin
        // previous run's last vertex must leave the holding register first
        if (cmd_valid_i && !pv_q) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.store) n_d = n_q + 1'b1;
          if (cmd_i.last) begin
            j_d = '0;
            if (n_d == '0) st_d = ST_LOAD;
            else if (n_d < CntW'(MinWrap)) st_d = ST_SMALL0;
            else begin
              st_d = ST_MIN; start_d = '0;
            end
          end
        end
      end
      ST_SMALL0: begin
        // rd data of entry 0 arrives next cycle
        j_d = CntW'(1); st_d = ST_SMALL1;
      end
      ST_SMALL1: begin
        // ox0 holds point 0 after this cycle
        if (ofree) begin
          if (j_q == CntW'(2)) begin
            st_d = ST_LOAD; n_d = '0;
          end else if (n_q == CntW'(1)) begin
            st_d = ST_LOAD; n_d = '0;
          end else begin
            j_d = CntW'(2);
          end
        end
      end
      ST_MIN: begin
        // j_q addresses read; data of j_q-1 present
        if (j_q != '0) begin
          if (j_q == CntW'(1) || lower) begin
            start_d = j_q[AW-1:0] - 1'b1; sx_d = rx_q; sy_d = ry_q;
          end
        end
        if (j_q == n_q) begin
          st_d = ST_EMIT; base_d = start_d; cur_d = start_d;
          rem_d = '0;
          for (int k = 0; k < MaxPoints; k++)
            if (CntW'(k) < n_q) rem_d[k] = 1'b1;
          emitted_d = '0;
        end else j_d = j_q + 1'b1;
      end
      ST_EMIT: begin
        if (ofree) begin
          emitted_d = emitted_q + 1'b1;
          if (emitted_q != '0) rem_d[cur_q] = 1'b0;
          base_d = cur_q;
          if (emitted_d == CntW'(MaxPoints)) begin
            st_d = ST_LOAD; n_d = '0; fin_d = 1'b1;
          end else begin
            st_d = ST_SCAN_RD; j_d = '0; have_d = 1'b0;
          end
        end
      end
      ST_SCAN_RD: begin
        st_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (rem_q[j_q[AW-1:0]]) begin
          if (!have_q) begin
            if (!(j_q[AW-1:0] == base_q && base_q == start_q && emitted_q == CntW'(1))) begin
              cur_d = j_q[AW-1:0]; have_d = 1'b1;
            end
          end else if (better) cur_d = j_q[AW-1:0];
        end
        if (j_q + 1'b1 == n_q) st_d = ST_DECIDE;
        else begin
          j_d = j_q + 1'b1; st_d = ST_SCAN_RD;
        end
      end
      ST_DECIDE: begin
        if (!have_q || cur_q == start_q) begin
          if (ofree) begin
            st_d = ST_LOAD; n_d = '0; fin_d = 1'b1;
          end
        end else st_d = ST_EMIT;
      end
      default: st_d = ST_LOAD;
    endcase
  end

  // current-choice coordinates come from the read port
  logic cap_c;
  assign cap_c = (st_q == ST_SCAN_CMP) && (cur_d != cur_q || (!have_q && have_d));

  // output staging: a vertex beat is formed in ST_EMIT and ST_SMALL1;
  // the last flag is applied to the held beat when the run ends.
  always_comb begin
    ox_d = cx_q; oy_d = cy_q; oidx_d = cur_q; olast_d = 1'b0; opush = 1'b0;
    if (st_q == ST_SMALL1 && ofree) begin
      ox_d = rx_q; oy_d = ry_q; oidx_d = j_q[AW-1:0] - 1'b1; opush = 1'b1;
      if (j_q == CntW'(2) && rx_q == ox0_q && ry_q == oy0_q) opush = 1'b0;
    end else if (st_q == ST_EMIT && ofree) begin
      opush = 1'b1;
    end
  end

  // pending vertex waits for next one (or end) to know its last flag
  always_ff @(posedge clk_i) begin
    if (st_q == ST_SMALL1 && j_q == CntW'(1)) begin
      ox0_q <= rx_q; oy0_q <= ry_q;
    end
    if (cap_c) begin
      cx_q <= rx_q; cy_q <= ry_q;
    end
    if (st_q == ST_MIN && j_q == n_q) begin
      cx_q <= sx_d; cy_q <= sy_d;
    end
    if (st_q == ST_EMIT && ofree) begin
      bx_q <= cx_q; by_q <= cy_q;
    end
    if (opush) begin
      pend_q.hull_x       <= ox_d;
      pend_q.hull_y       <= oy_d;
      pend_q.vertex_index <= IdxW'(oidx_d);
      pend_q.last_vertex  <= olast_d;
    end
    if (ofree && pv_q && (opush || fin_d || st_q == ST_LOAD)) begin
      obuf_q.hull_x       <= pend_q.hull_x;
      obuf_q.hull_y       <= pend_q.hull_y;
      obuf_q.vertex_index <= pend_q.vertex_index;
      obuf_q.last_vertex  <= !opush;
    end
    sx_q <= sx_d; sy_q <= sy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_LOAD; n_q <= '0; j_q <= '0; rem_q <= '0; start_q <= '0;
      base_q <= '0; cur_q <= '0; have_q <= 1'b0; emitted_q <= '0;
      pv_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; n_q <= n_d; j_q <= j_d; rem_q <= rem_d; start_q <= start_d;
      base_q <= base_d; cur_q <= cur_d; have_q <= have_d; emitted_q <= emitted_d;
      if (ofree) begin
        if (pv_q && (opush || fin_d || st_q == ST_LOAD)) ov_q <= 1'b1;
        else ov_q <= 1'b0;
        if (opush) pv_q <= 1'b1;
        else if (pv_q && (fin_d || st_q == ST_LOAD)) pv_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/convex_hull_gift_wrap.sv =====
// ----------------------------------------------------------------------------
// convex_hull_gift_wrap
// 2D convex hull by gift wrapping over a stored point set.
// ----------------------------------------------------------------------------
// channel | dir | payload    | handshake
// in      | in  | pt_in_t    | in_valid / in_stall
// out     | out | hull_out_t | out_valid / out_stall
//
// Load beats pass one per cycle through a two-entry queue while it has room.
// Each hull vertex scans every stored point in a read state and a compare state
// (one memory read port). The start vertex search takes one stored point per cycle.
// Reset clears control only; the point store needs no clearing.
// Stalls on out hold the sequencer; the queue absorbs in beats meanwhile.
// A new set loads only once the previous run's last vertex is in the out register.
// ----------------------------------------------------------------------------
`default_nettype none

module convex_hull_gift_wrap import chgw_pkg::*; #(
  parameter int unsigned MaxPoints = MaxPointsDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire pt_in_t    in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output hull_out_t      out_data
);

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  chgw_front #(.MaxPoints(MaxPoints)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  chgw_back #(.MaxPoints(MaxPoints)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .out_valid, .out_stall, .out_data
  );

endmodule

`default_nettype wire

// ===== hw/rtl/chgw_checker.sv =====
// ----------------------------------------------------------------------------
// chgw_checker
// Port-level checks on the convex hull block.
// ----------------------------------------------------------------------------
`default_nettype none

module chgw_checker import chgw_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire hull_out_t out_data
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("out beat dropped under stall");

  a_no_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !$isunknown(out_data.last_vertex))
    else $error("unknown last flag");

  a_in_stall_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(in_stall))
    else $error("in stall unknown");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_stall |=> in_valid)
    else $error("in beat withdrawn under stall");

endmodule

bind convex_hull_gift_wrap chgw_checker u_chk (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for convex_hull_gift_wrap: point sets are streamed in, and every
// hull vertex is checked against a gift-wrap predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import chgw_pkg::*;

  localparam int unsigned NPts = MaxPointsDef;
  localparam int unsigned NItems = 130;
  localparam longint MaxCycles = 4000000;

  class hull_scoreboard;
    logic signed [CoordW-1:0] xs[NPts];
    logic signed [CoordW-1:0] ys[NPts];
    int unsigned count;
    hull_out_t vertex_q[$];
    bit failed;

    function new();
      count = 0;
      failed = 0;
    endfunction

    function void push_vertex(int unsigned idx);
      hull_out_t v;
      v.hull_x = xs[idx];
      v.hull_y = ys[idx];
      v.vertex_index = IdxW'(idx);
      v.last_vertex = 1'b0;
      vertex_q.push_back(v);
    endfunction

    function longint dist2(int unsigned p, int unsigned q);
      longint dx, dy;
      dx = longint'(xs[q]) - longint'(xs[p]);
      dy = longint'(ys[q]) - longint'(ys[p]);
      return dx * dx + dy * dy;
    endfunction

    function bit replaces(int unsigned b, int unsigned cur, int unsigned k);
      longint x1, y1, x2, y2, det;
      x1 = longint'(xs[cur]) - longint'(xs[b]);
      y1 = longint'(ys[cur]) - longint'(ys[b]);
      x2 = longint'(xs[k]) - longint'(xs[b]);
      y2 = longint'(ys[k]) - longint'(ys[b]);
      det = x1 * y2 - x2 * y1;
      if (det < 0) return 1'b1;
      return det == 0 && dist2(b, k) > dist2(b, cur);
    endfunction

    function void wrap_hull();
      bit [NPts-1:0] live;
      int unsigned first, base, cur, emitted;
      bit have;
      if (count == 0) return;
      if (count < MinWrap) begin
        push_vertex(0);
        if (count == 2 && !(xs[0] == xs[1] && ys[0] == ys[1])) push_vertex(1);
      end else begin
        live = '0;
        for (int j = 0; j < count; j++) live[j] = 1'b1;
        first = 0;
        for (int j = 1; j < count; j++)
          if (ys[j] < ys[first] || (ys[j] == ys[first] && xs[j] < xs[first])) first = j;
        push_vertex(first);
        emitted = 1;
        base = first;
        cur = 0;
        while (emitted < NPts) begin
          have = 0;
          for (int j = 0; j < count; j++) begin
            if (!live[j]) continue;
            if (!have) begin
              if (j == base && base == first && emitted == 1) continue;
              cur = j;
              have = 1;
            end else if (replaces(base, cur, j)) begin
              cur = j;
            end
          end
          if (!have || cur == first) break;
          push_vertex(cur);
          emitted++;
          live[cur] = 1'b0;
          base = cur;
        end
      end
      vertex_q[$].last_vertex = 1'b1;
    endfunction

    function void note_point(pt_in_t p);
      if (count < NPts) begin
        xs[count] = p.point_x;
        ys[count] = p.point_y;
        count++;
      end
      if (p.last_point) begin
        wrap_hull();
        count = 0;
      end
    endfunction

    function void check_vertex(hull_out_t got);
      hull_out_t exp_v;
      if (vertex_q.size() == 0) begin
        $error("unexpected hull vertex %p", got);
        failed = 1;
        return;
      end
      exp_v = vertex_q.pop_front();
      if (got.hull_x !== exp_v.hull_x) begin
        $error("hull_x expected %0d got %0d", exp_v.hull_x, got.hull_x);
        failed = 1;
      end
      if (got.hull_y !== exp_v.hull_y) begin
        $error("hull_y expected %0d got %0d", exp_v.hull_y, got.hull_y);
        failed = 1;
      end
      if (got.vertex_index !== exp_v.vertex_index) begin
        $error("vertex_index expected %0d got %0d", exp_v.vertex_index, got.vertex_index);
        failed = 1;
      end
      if (got.last_vertex !== exp_v.last_vertex) begin
        $error("last_vertex expected %0d got %0d", exp_v.last_vertex, got.last_vertex);
        failed = 1;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pt_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  hull_out_t out_data;

  hull_scoreboard hull_sb = new();
  longint cycle_cnt = 0;
  int unsigned n_sent = 0;
  bit hold_off = 0;
  bit narrow = 0;

  convex_hull_gift_wrap dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    if (narrow) return CoordW'($signed($urandom_range(0, 8)) - 4);
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return CoordW'($urandom);
    endcase
  endfunction

  task automatic send_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                            logic last);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= '{point_x: x, point_y: y, last_point: last};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    hull_sb.note_point(in_data);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_point(rand_coord(), rand_coord(), i == n - 1);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_ni && out_valid && !out_stall) hull_sb.check_vertex(out_data);
    if (cycle_cnt > MaxCycles) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned g;
    @(negedge clk_i);
    forever begin
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (2000) @(negedge clk_i);
        hold_off = 0;
      end
      g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
      out_stall <= g != 0;
      repeat (g == 0 ? 1 : g) @(negedge clk_i);
    end
  end

  initial begin
    int unsigned n;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // single point, two equal, two distinct
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    send_point(16'sd5, 16'sd5, 1'b0);
    send_point(16'sd5, 16'sd5, 1'b1);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b1);
    // square with collinear edge point, duplicate and interior point
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd4, 16'sd0, 1'b0);
    send_point(16'sd2, 16'sd0, 1'b0);
    send_point(16'sd4, 16'sd4, 1'b0);
    send_point(16'sd0, 16'sd4, 1'b0);
    send_point(16'sd4, 16'sd4, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b1);
    // all collinear, then extremes of the coordinate range
    send_point(16'sd1, 16'sd1, 1'b0);
    send_point(16'sd3, 16'sd3, 1'b0);
    send_point(16'sd2, 16'sd2, 1'b1);
    send_point(16'sh8000, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b1);
    // overflowing the store, receiver held off so the block backs up
    hold_off = 1;
    narrow = 1;
    send_set(NPts + 3);
    narrow = 0;
    while (n_sent < NItems) begin
      narrow = $urandom_range(0, 1);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 12);
      if (n > NItems - n_sent) n = NItems - n_sent;
      send_set(n);
    end
    in_valid <= 1'b0;
    while (hull_sb.vertex_q.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (!hull_sb.failed) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

`default_nettype wire
